// File: hw/rtl/acm_pkg.sv
// shared widths, action codes and opcodes of the accumulator machine
`default_nettype none

package acm_pkg;

  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int ACT_W     = 2;
  localparam int OP_W      = 4;
  localparam int OP_LSB    = 13;
  localparam int IMM_BIT   = 31;
  localparam int LINES_DEF = 32;

  // slave tdata: word_addr, word_data, padded to whole bytes
  localparam int S_DATA_W = 40;
  // master tdata: four words and two flags, padded to whole bytes
  localparam int M_DATA_W = 136;

  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STEP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd3;

  localparam logic [OP_W-1:0] OP_JMP  = 4'd0;
  localparam logic [OP_W-1:0] OP_JRP  = 4'd1;
  localparam logic [OP_W-1:0] OP_LDN  = 4'd2;
  localparam logic [OP_W-1:0] OP_STO  = 4'd3;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd4;
  localparam logic [OP_W-1:0] OP_SUB2 = 4'd5;
  localparam logic [OP_W-1:0] OP_CMP  = 4'd6;
  localparam logic [OP_W-1:0] OP_STP  = 4'd7;
  localparam logic [OP_W-1:0] OP_LDA  = 4'd8;
  localparam logic [OP_W-1:0] OP_STN  = 4'd9;
  localparam logic [OP_W-1:0] OP_ADD  = 4'd10;
  localparam logic [OP_W-1:0] OP_LAST = OP_ADD;

endpackage

`default_nettype wire

// File: hw/rtl/accumulator_machine_core.sv
// accumulator machine: store memory, accumulator, counter and step sequencer
//
//  channel | dir | handshake               | payload
//  s_      | in  | s_tvalid / s_tready     | s_tuser action, s_tdata word_addr, word_data
//  m_      | out | m_tvalid / m_tready     | m_tdata read_data .. bad_opcode
//
// a load passes issue and done, a read issue, read wait and done, a step issue, fetch,
// operand and done, set by the single read port of the store memory with its registered
// read data; a bad opcode leaves fetch for done, a restart or a halted step goes to done.
// when LINES is not a power of two each address goes through a reciprocal-multiply
// remainder unit, adding multiply, scale and reduce steps to every load, read and
// running step. after reset a clearing pass writes zero to the store with s_tready low.
// one word is in flight at a time; the next is taken while a result waits in m_tdata.
`default_nettype none

module accumulator_machine_core
  import acm_pkg::*;
#(
  parameter int LINES = LINES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [4:0] word_addr, [36:5] word_data, rest zero
  input  wire logic [S_DATA_W-1:0]  s_tdata,
  // [1:0] action
  input  wire logic [ACT_W-1:0]     s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [31:0] read_data, [63:32] acc_value, [95:64] counter_value,
  // [127:96] fetched_word, [128] halted, [129] bad_opcode, rest zero
  output logic [M_DATA_W-1:0]       m_tdata
);

  localparam int LB           = $clog2(LINES);
  localparam bit LinesPow2    = (LINES & (LINES - 1)) == 0;
  localparam int MulSh        = WORD_W + LB;
  localparam longint RecipFull = (longint'(1) << MulSh) / longint'(LINES);
  localparam logic [WORD_W:0] Recip = (WORD_W+1)'(RecipFull);
  localparam logic [WORD_W-1:0] LinesW = WORD_W'(LINES);
  localparam logic [LB:0] LinesV = (LB+1)'(LINES);
  localparam logic [LB-1:0] LinesM1 = LB'(LINES - 1);
  localparam logic [1:0] ModMul   = 2'd0;
  localparam logic [1:0] ModScale = 2'd1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_ISSUE  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_FETCH  = 3'd5;
  localparam logic [2:0] S_OPER   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]          state;
  logic [LB-1:0]       clr_idx;
  logic [ACT_W-1:0]    act_q;
  logic [WORD_W-1:0]   wdata_q;
  logic [WORD_W-1:0]   div_sh;
  logic [2*WORD_W:0]   mod_prod;
  logic [WORD_W-1:0]   mod_quot;
  logic [WORD_W-1:0]   mod_qmul;
  logic [WORD_W-1:0]   mod_diff;
  logic [LB-1:0]       rem;
  logic [LB-1:0]       rem_red;
  logic [1:0]          mod_cnt;
  logic [WORD_W-1:0]   acc;
  logic [WORD_W-1:0]   counter;
  logic [WORD_W-1:0]   pw;
  logic                stopped;
  logic [WORD_W-1:0]   rd_val;
  logic                bad;
  logic [M_DATA_W-1:0] out_word;

  logic [WORD_W-1:0]   mem [LINES];
  logic [WORD_W-1:0]   rd_q;
  logic                mem_we;
  logic [LB-1:0]       mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;
  logic [LB-1:0]       mem_raddr;

  logic [LB-1:0]       idx;
  logic [OP_W-1:0]     fetch_op;
  logic [OP_W-1:0]     oper_op;
  logic [LB-1:0]       oper_line;
  logic [WORD_W-1:0]   oper_data;
  logic                s_acc;
  logic                out_free;

  // line field reduced mod LINES: it is below twice LINES
  function automatic logic [LB-1:0] line_idx(input logic [WORD_W-1:0] w);
    logic [LB:0] l;
    l = {1'b0, w[LB-1:0]};
    if (l >= LinesV) begin
      l = l - LinesV;
    end
    return l[LB-1:0];
  endfunction

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = out_word;

  // remainder unit: quotient estimate by reciprocal, at most one short
  assign mod_quot = {{(LB-1){1'b0}}, mod_prod[2*WORD_W:MulSh]};
  assign mod_diff = div_sh - mod_qmul;
  assign rem_red  = (mod_diff >= LinesW) ? LB'(mod_diff - LinesW) : mod_diff[LB-1:0];

  assign idx       = LinesPow2 ? div_sh[LB-1:0] : rem;
  assign fetch_op  = rd_q[OP_LSB +: OP_W];
  assign oper_op   = pw[OP_LSB +: OP_W];
  assign oper_line = line_idx(pw);
  assign oper_data = pw[IMM_BIT] ? {{(WORD_W-LB){1'b0}}, pw[LB-1:0]} : rd_q;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = wdata_q;
    mem_raddr = idx;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      S_ISSUE: begin
        mem_we = (act_q == ACT_LOAD);
      end
      S_FETCH: begin
        mem_raddr = line_idx(rd_q);
      end
      S_OPER: begin
        mem_waddr = oper_line;
        if (oper_op == OP_STO) begin
          mem_we    = 1'b1;
          mem_wdata = acc;
        end else if (oper_op == OP_STN) begin
          mem_we    = 1'b1;
          mem_wdata = (~acc) + 1'b1;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      acc      <= '0;
      counter  <= '0;
      pw       <= '0;
      stopped  <= 1'b0;
      m_tvalid <= 1'b0;
      mod_cnt  <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LinesM1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_acc) begin
            act_q   <= s_tuser;
            wdata_q <= s_tdata[ADDR_W +: WORD_W];
            rd_val  <= '0;
            bad     <= 1'b0;
            mod_cnt <= '0;
            if (s_tuser == ACT_RESTART) begin
              acc     <= '0;
              counter <= '0;
              pw      <= '0;
              stopped <= 1'b0;
              state   <= S_DONE;
            end else if ((s_tuser == ACT_STEP) && stopped) begin
              state <= S_DONE;
            end else begin
              state <= LinesPow2 ? S_ISSUE : S_MOD;
              if (s_tuser == ACT_STEP) begin
                counter <= counter + 1'b1;
                div_sh  <= counter + 1'b1;
              end else begin
                div_sh <= {{(WORD_W-ADDR_W){1'b0}}, s_tdata[ADDR_W-1:0]};
              end
            end
          end
        end
        S_MOD: begin
          mod_cnt <= mod_cnt + 1'b1;
          if (mod_cnt == ModMul) begin
            mod_prod <= {{(WORD_W+1){1'b0}}, div_sh} * {{WORD_W{1'b0}}, Recip};
          end else if (mod_cnt == ModScale) begin
            mod_qmul <= mod_quot * LinesW;
          end else begin
            rem   <= rem_red;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          case (act_q)
            ACT_LOAD: state <= S_DONE;
            ACT_READ: state <= S_RDWAIT;
            default:  state <= S_FETCH;
          endcase
        end
        S_RDWAIT: begin
          rd_val <= rd_q;
          state  <= S_DONE;
        end
        S_FETCH: begin
          pw <= rd_q;
          if (fetch_op > OP_LAST) begin
            bad   <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_OPER;
          end
        end
        S_OPER: begin
          case (oper_op)
            OP_JMP:           counter <= oper_data;
            OP_JRP:           counter <= counter - oper_data;
            OP_LDN:           acc     <= (~oper_data) + 1'b1;
            OP_SUB, OP_SUB2:  acc     <= acc - oper_data;
            OP_CMP: begin
              if (acc[WORD_W-1]) begin
                counter <= counter + 1'b1;
              end
            end
            OP_STP:           stopped <= 1'b1;
            OP_LDA:           acc     <= oper_data;
            OP_ADD:           acc     <= acc + oper_data;
            default: begin
              // stores go through the memory port
            end
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_word <= {{(M_DATA_W-4*WORD_W-2){1'b0}}, bad, stopped,
                         pw, counter, acc, rd_val};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/acm_checker.sv
// port checker for the accumulator machine, bound to the top level
`default_nettype none

module acm_checker
  import acm_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic [S_DATA_W-1:0] s_tdata,
  input wire logic [ACT_W-1:0]    s_tuser,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // one word in flight: an accepted word closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in flight");

  // reset starts the clearing pass with nothing shown
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("ports active right after reset");

  // a bad opcode comes from a step that ran, so not halted and no read data
  a_bad_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[129] |-> !m_tdata[128] && (m_tdata[31:0] == '0))
    else $error("bad opcode reported with halted or read data");

endmodule

bind accumulator_machine_core acm_checker u_acm_checker (.*);

`default_nettype wire
